// ===== src/lpi_pkg.sv =====
// Shared types and constants for the line and plane intersection core.
// No dependencies; every other file imports this package.
`default_nettype none
package lpi_pkg;

    localparam int ProdW = 64;
    localparam int SumW  = 66;
    localparam int DenW  = 66;
    localparam int NumW  = 100;
    localparam int QW    = 32;
    localparam int DivSteps = QW;
    localparam int FifoDepth = 4;
    localparam int FifoAw = $clog2(FifoDepth);

    localparam logic [QW-1:0] QMax = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] QMin = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_d;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic               is_parallel;
        logic               overflowed;
    } out_t;

    // Word handed from the front end to the back end through the queue.
    typedef struct packed {
        logic [2:0][31:0]   pt;
        logic [2:0][31:0]   dir;
        logic [2:0][SumW-1:0] sa;
        logic [2:0][SumW-1:0] sb;
        logic [DenW-1:0]    dm;
        logic               dneg;
        logic               dzero;
    } qitem_t;

    // One stage of the three-lane restoring divider.
    typedef struct packed {
        logic [DenW-1:0]      dm;
        logic [2:0][DenW-1:0] r;
        logic [2:0][QW-1:0]   n;
        logic [2:0][QW-1:0]   q;
        logic [2:0]           ovf;
        logic [2:0]           neg;
        logic                 dzero;
    } div_t;

endpackage
`default_nettype wire

// ===== src/lpi_front.sv =====
// Front end: products, plane sums and denominator magnitude, three stages.
// Depends on lpi_pkg.
`default_nettype none
module lpi_front
    import lpi_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire in_t    in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output qitem_t      out_data
);

    typedef struct packed {
        logic signed [ProdW-1:0] axn, byn, czn, ax0, by0, cz0;
        logic signed [31:0]      d;
        logic [2:0][31:0]        pt;
        logic [2:0][31:0]        dir;
    } f1_t;

    typedef struct packed {
        logic signed [DenW-1:0]  den;
        logic [2:0][SumW-1:0]    sa;
        logic [2:0][SumW-1:0]    sb;
        logic [2:0][31:0]        pt;
        logic [2:0][31:0]        dir;
    } f2_t;

    logic   v1_reg, v2_reg, v3_reg;
    f1_t    f1_reg, f1_next;
    f2_t    f2_reg, f2_next;
    qitem_t f3_reg, f3_next;
    logic   en;
    logic signed [SumW-1:0] d16;

    assign en        = !v3_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v3_reg;
    assign out_data  = f3_reg;

    always_comb begin
        f1_next.axn = in_data.coef_a * in_data.dir_x;
        f1_next.byn = in_data.coef_b * in_data.dir_y;
        f1_next.czn = in_data.coef_c * in_data.dir_z;
        f1_next.ax0 = in_data.coef_a * in_data.point_x;
        f1_next.by0 = in_data.coef_b * in_data.point_y;
        f1_next.cz0 = in_data.coef_c * in_data.point_z;
        f1_next.d   = in_data.coef_d;
        f1_next.pt  = {in_data.point_z, in_data.point_y, in_data.point_x};
        f1_next.dir = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
    end

    always_comb begin
        d16 = SumW'(f1_reg.d) <<< 16;
        f2_next.den   = DenW'(f1_reg.axn) + DenW'(f1_reg.byn) + DenW'(f1_reg.czn);
        f2_next.sa[0] = SumW'(f1_reg.byn) + SumW'(f1_reg.czn);
        f2_next.sa[1] = SumW'(f1_reg.axn) + SumW'(f1_reg.czn);
        f2_next.sa[2] = SumW'(f1_reg.axn) + SumW'(f1_reg.byn);
        f2_next.sb[0] = SumW'(f1_reg.by0) + SumW'(f1_reg.cz0) + d16;
        f2_next.sb[1] = SumW'(f1_reg.ax0) + SumW'(f1_reg.cz0) + d16;
        f2_next.sb[2] = SumW'(f1_reg.ax0) + SumW'(f1_reg.by0) + d16;
        f2_next.pt    = f1_reg.pt;
        f2_next.dir   = f1_reg.dir;
    end

    always_comb begin
        f3_next.pt    = f2_reg.pt;
        f3_next.dir   = f2_reg.dir;
        f3_next.sa    = f2_reg.sa;
        f3_next.sb    = f2_reg.sb;
        f3_next.dneg  = f2_reg.den[DenW-1];
        f3_next.dzero = (f2_reg.den == '0);
        f3_next.dm    = f2_reg.den[DenW-1] ? DenW'(-f2_reg.den) : DenW'(f2_reg.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/lpi_queue.sv =====
// Short word queue between front and back ends.
// Depends on lpi_pkg.
`default_nettype none
module lpi_queue
    import lpi_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_valid,
    output logic        wr_ready,
    input  wire qitem_t wr_data,
    output logic        rd_valid,
    input  wire logic   rd_ready,
    output qitem_t      rd_data
);

    qitem_t             mem_reg [FifoDepth];
    logic [FifoAw-1:0]  wp_reg, rp_reg;
    logic [FifoAw:0]    cnt_reg, cnt_next;
    logic               push, pop;

    assign wr_ready = (cnt_reg != FifoAw'(0) + (FifoAw+1)'(FifoDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/lpi_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on lpi_pkg.
`default_nettype none
module lpi_div
    import lpi_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire div_t in_data,
    output logic      out_valid,
    output div_t      out_data
);

    logic stg_v [DivSteps+1];
    div_t stg_d [DivSteps+1];

    assign stg_v[0]  = in_valid;
    assign stg_d[0]  = in_data;
    assign out_valid = stg_v[DivSteps];
    assign out_data  = stg_d[DivSteps];

    for (genvar i = 0; i < DivSteps; i++) begin : g_stage
        logic v_reg;
        div_t d_reg, d_next;
        logic [DenW:0] t;
        logic          ge;

        always_comb begin
            d_next = stg_d[i];
            t  = '0;
            ge = 1'b0;
            for (int k = 0; k < 3; k++) begin
                t  = {stg_d[i].r[k], stg_d[i].n[k][QW-1]};
                ge = (t >= {1'b0, stg_d[i].dm});
                d_next.r[k] = ge ? DenW'(t - {1'b0, stg_d[i].dm}) : t[DenW-1:0];
                d_next.n[k] = {stg_d[i].n[k][QW-2:0], 1'b0};
                d_next.q[k] = {stg_d[i].q[k][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= stg_v[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg <= d_next;
            end
        end

        assign stg_v[i+1] = v_reg;
        assign stg_d[i+1] = d_reg;
    end

endmodule
`default_nettype wire

// ===== src/lpi_back.sv =====
// Back end: numerators, magnitudes, divider and saturating output register.
// Depends on lpi_pkg and lpi_div.
`default_nettype none
module lpi_back
    import lpi_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire qitem_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output out_t        out_data
);

    typedef struct packed {
        logic [2:0][64:0] pl_a, pl_b;
        logic [2:0][65:0] ph_a, ph_b;
        logic [DenW-1:0]  dm;
        logic             dneg, dzero;
    } b1_t;

    typedef struct packed {
        logic [2:0][NumW-1:0] p1, p2;
        logic [DenW-1:0]      dm;
        logic                 dneg, dzero;
    } b2_t;

    typedef struct packed {
        logic [2:0][NumW-1:0] num;
        logic [DenW-1:0]      dm;
        logic                 dneg, dzero;
    } b3_t;

    typedef struct packed {
        logic [2:0][NumW-1:0] nm;
        logic [2:0]           neg;
        logic [DenW-1:0]      dm;
        logic                 dzero;
    } b4_t;

    logic   en;
    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, ov_reg;
    b1_t    b1_reg, b1_next;
    b2_t    b2_reg, b2_next;
    b3_t    b3_reg, b3_next;
    b4_t    b4_reg, b4_next;
    div_t   b5_reg, b5_next;
    out_t   o_reg, o_next;
    logic   dv;
    div_t   dd;

    assign en        = !ov_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = ov_reg;
    assign out_data  = o_reg;

    // Each wide sum is split into a low unsigned word and a signed high part,
    // so every multiplier stays near 32 by 32 bits.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b1_next.pl_a[k] = $signed(in_data.pt[k])  * $signed({1'b0, in_data.sa[k][31:0]});
            b1_next.ph_a[k] = $signed(in_data.pt[k])  * $signed(in_data.sa[k][SumW-1:32]);
            b1_next.pl_b[k] = $signed(in_data.dir[k]) * $signed({1'b0, in_data.sb[k][31:0]});
            b1_next.ph_b[k] = $signed(in_data.dir[k]) * $signed(in_data.sb[k][SumW-1:32]);
        end
        b1_next.dm    = in_data.dm;
        b1_next.dneg  = in_data.dneg;
        b1_next.dzero = in_data.dzero;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b2_next.p1[k] = (NumW'($signed(b1_reg.ph_a[k])) <<< 32)
                          + NumW'($signed(b1_reg.pl_a[k]));
            b2_next.p2[k] = (NumW'($signed(b1_reg.ph_b[k])) <<< 32)
                          + NumW'($signed(b1_reg.pl_b[k]));
        end
        b2_next.dm    = b1_reg.dm;
        b2_next.dneg  = b1_reg.dneg;
        b2_next.dzero = b1_reg.dzero;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b3_next.num[k] = b2_reg.p1[k] - b2_reg.p2[k];
        end
        b3_next.dm    = b2_reg.dm;
        b3_next.dneg  = b2_reg.dneg;
        b3_next.dzero = b2_reg.dzero;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            b4_next.nm[k]  = b3_reg.num[k][NumW-1] ? -b3_reg.num[k] : b3_reg.num[k];
            b4_next.neg[k] = b3_reg.num[k][NumW-1] ^ b3_reg.dneg;
        end
        b4_next.dm    = b3_reg.dm;
        b4_next.dzero = b3_reg.dzero;
    end

    // A quotient of 2^32 or more saturates outright; below that the upper
    // numerator bits are already smaller than the divisor.
    always_comb begin
        b5_next.dm    = b4_reg.dm;
        b5_next.dzero = b4_reg.dzero;
        b5_next.neg   = b4_reg.neg;
        for (int k = 0; k < 3; k++) begin
            b5_next.ovf[k] = (b4_reg.nm[k] >= NumW'({b4_reg.dm, 32'h0}));
            b5_next.r[k]   = b4_reg.nm[k][DenW+31:32];
            b5_next.n[k]   = b4_reg.nm[k][31:0];
            b5_next.q[k]   = '0;
        end
    end

    lpi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_data   (b5_reg),
        .out_valid (dv),
        .out_data  (dd)
    );

    always_comb begin
        logic [2:0][QW-1:0] h;
        logic [2:0]         sat;
        for (int k = 0; k < 3; k++) begin
            sat[k] = 1'b0;
            if (dd.ovf[k]) begin
                sat[k] = 1'b1;
                h[k]   = dd.neg[k] ? QMin : QMax;
            end else if (!dd.neg[k]) begin
                sat[k] = (dd.q[k] > QMax);
                h[k]   = sat[k] ? QMax : dd.q[k];
            end else begin
                sat[k] = (dd.q[k] > QMin);
                h[k]   = sat[k] ? QMin : QW'(-dd.q[k]);
            end
        end
        if (dd.dzero) begin
            o_next.hit_x       = '0;
            o_next.hit_y       = '0;
            o_next.hit_z       = '0;
            o_next.is_parallel = 1'b1;
            o_next.overflowed  = 1'b0;
        end else begin
            o_next.hit_x       = h[0];
            o_next.hit_y       = h[1];
            o_next.hit_z       = h[2];
            o_next.is_parallel = 1'b0;
            o_next.overflowed  = |sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            ov_reg <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            b4_reg <= b4_next;
            b5_reg <= b5_next;
            o_reg  <= o_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/line_plane_intersection_core.sv =====
// Top level of the line and plane intersection core.
// Depends on lpi_pkg, lpi_front, lpi_queue and lpi_back.
`default_nettype none
// The core accepts one word per clock while the result channel is not stalled,
// and returns one result word per input word, in order. Each word holds a
// plane a*x+b*y+c*z+d=0, a point and a direction, all signed Q16.16, and the
// result is the intersection point in Q16.16, truncated toward zero and
// saturated to 32 bits (overflowed set when any coordinate saturates). A zero
// denominator returns zeros with is_parallel set. Sustained throughput is one
// word per cycle. From input to output a word passes the front-end registers,
// the four-word queue, the numerator and setup registers, the divider stages
// (one quotient bit per stage) and the output register. The front end and
// back end stall independently, so a stalled result channel fills the queue
// before the input channel backs up.
module line_plane_intersection_core
    import lpi_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic   fq_valid, fq_ready, qb_valid, qb_ready;
    qitem_t fq_data, qb_data;

    // Products, plane sums and the denominator magnitude.
    lpi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_data  (fq_data)
    );

    // The queue decouples the front and back stall domains.
    lpi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // Numerators, division and saturation, ending in the output register.
    lpi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_data   (qb_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire
